// File: hdl/sbv_pkg.sv
// Shared constants, types and saturation helpers of the skinned vertex blend unit.
package sbv_pkg;

   localparam int MAX_VERTS   = 4096;
   localparam int FRAC_BITS   = 16;
   localparam int WEIGHT_FRAC = 16;
   localparam int VADDR_W     = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;

   localparam int XF_WORDS = 13;
   localparam int XF_TX    = 9;
   localparam int XF_SCALE = 12;

   localparam int WORD_W  = 32;
   localparam int WGT_W   = 17;
   localparam int MUL_W   = WORD_W + 1;
   localparam int PROD_W  = 2 * MUL_W - FRAC_BITS;
   localparam int SUM_W   = PROD_W + 2;
   localparam int ACC_W   = 48;
   localparam int WSUM_W  = 32;
   localparam int DIVD_W  = ACC_W + WEIGHT_FRAC;
   localparam int RAM_W   = 3 * ACC_W + WSUM_W;
   localparam int WSUM_LO = 3 * ACC_W;

   localparam logic [WSUM_W-1:0] WSUM_MIN = WSUM_W'(6);

   localparam logic signed [SUM_W-1:0] S32_MAX = SUM_W'(64'sh0000_0000_7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] S32_MIN = SUM_W'(-(64'sh0000_0000_8000_0000));
   localparam logic signed [SUM_W-1:0] S48_MAX = SUM_W'(64'sh0000_7FFF_FFFF_FFFF);
   localparam logic signed [SUM_W-1:0] S48_MIN = SUM_W'(-(64'sh0000_8000_0000_0000));

   typedef enum logic [2:0] {
      OP_LOAD    = 3'd0,
      OP_COMPOSE = 3'd1,
      OP_ACCUM   = 3'd2,
      OP_EMIT    = 3'd3,
      OP_RIGID   = 3'd4,
      OP_DIR     = 3'd5
   } op_type;

   // Reset word of a transform: identity rotation, zero translation, unit scale
   function automatic logic signed [WORD_W-1:0] xf_reset(input int idx);
      logic signed [WORD_W-1:0] one;
      one = WORD_W'(1) << FRAC_BITS;
      if (idx == 0 || idx == 4 || idx == 8 || idx == XF_SCALE) begin
         return one;
      end
      return '0;
   endfunction

   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      if (v > S32_MAX) begin
         return WORD_W'(S32_MAX);
      end
      if (v < S32_MIN) begin
         return WORD_W'(S32_MIN);
      end
      return WORD_W'(v);
   endfunction

   function automatic logic signed [ACC_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
      if (v > S48_MAX) begin
         return ACC_W'(S48_MAX);
      end
      if (v < S48_MIN) begin
         return ACC_W'(S48_MIN);
      end
      return ACC_W'(v);
   endfunction

endpackage

// File: hdl/skinned_vertex_blend.sv
// Top level of the skinned vertex blend unit: sequencer, transforms and accumulator store.
//
// One transaction is worked on at a time; a finished result waits in the response register
// while the next transaction is taken. Work is paced by the one shared multiplier and the
// bit-serial divider: compose takes 40 products; rigid position and direction end in the
// finish step, which waits while the response register is still held; accumulate takes 15
// products plus the accumulator write-back; emit takes one 64-step division per component,
// or none on fallback. Skipped vertices and unused operations go straight back to idle.
// Per-vertex sums live in one RAM of MAX_VERTS rows; after reset a clearing pass zeroes it,
// during which req_ready stays low while csr writes are still taken.
module skinned_vertex_blend (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_operation,
   input  logic                               req_bank,
   input  logic [3:0]                         req_word_index,
   input  logic signed [31:0]                 req_word_value,
   input  logic [11:0]                        req_vertex_index,
   input  logic signed [31:0]                 req_pos_x,
   input  logic signed [31:0]                 req_pos_y,
   input  logic signed [31:0]                 req_pos_z,
   input  logic [16:0]                        req_weight,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [31:0]                 rsp_res_x,
   output logic signed [31:0]                 rsp_res_y,
   output logic signed [31:0]                 rsp_res_z,
   output logic [11:0]                        rsp_res_vertex,
   output logic                               rsp_used_fallback,
   input  logic                               csr_wr_en,
   input  logic [12:0]                        csr_wr_data
);

   localparam int W  = sbv_pkg::WORD_W;
   localparam int VW = sbv_pkg::VADDR_W;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_ISSUE, ST_CONS, ST_EMRD, ST_DIV, ST_WRITE, ST_FIN
   } state_type;

   typedef enum logic [2:0] {
      PH_ROT, PH_TDOT, PH_TSCL, PH_CSCL, PH_RDOT, PH_RSCL, PH_WGT
   } phase_type;

   state_type              state_ff, state_in;
   phase_type              phase_ff, phase_in;
   sbv_pkg::op_type        op_ff, op_in;
   logic [11:0]            vidx_ff, vidx_in;
   logic signed [W-1:0]    pin_ff [3];
   logic signed [W-1:0]    pin_in [3];
   logic [sbv_pkg::WGT_W-1:0] weight_ff, weight_in;
   logic [1:0]             i_ff, i_in, j_ff, j_in, k_ff, k_in, comp_ff, comp_in;
   logic signed [sbv_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic signed [W-1:0]    hold_ff, hold_in;
   logic signed [W-1:0]    r_ff [3];
   logic signed [W-1:0]    r_in [3];
   logic signed [sbv_pkg::ACC_W-1:0] acc_ff [3];
   logic signed [sbv_pkg::ACC_W-1:0] acc_in [3];
   logic                   fb_ff, fb_in;
   logic [VW-1:0]          clr_ff, clr_in;
   logic signed [W-1:0]    parent_ff [sbv_pkg::XF_WORDS];
   logic signed [W-1:0]    parent_in [sbv_pkg::XF_WORDS];
   logic signed [W-1:0]    local_ff  [sbv_pkg::XF_WORDS];
   logic signed [W-1:0]    local_in  [sbv_pkg::XF_WORDS];
   logic signed [W-1:0]    active_ff [sbv_pkg::XF_WORDS];
   logic signed [W-1:0]    active_in [sbv_pkg::XF_WORDS];
   logic [12:0]            vcount_ff, vcount_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0]    res_ff [3];
   logic signed [W-1:0]    res_in [3];
   logic [11:0]            res_vertex_ff, res_vertex_in;
   logic                   res_fb_ff, res_fb_in;

   logic [3:0]             par_idx, loc_idx, act_idx;
   logic signed [W-1:0]    par_rd, loc_rd, act_rd;
   logic signed [sbv_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic signed [sbv_pkg::PROD_W-1:0] mul_prod;
   logic signed [sbv_pkg::SUM_W-1:0]  s_dot, s_scl;
   logic signed [W-1:0]    offset;

   logic                   ram_we, ram_re;
   logic [VW-1:0]          ram_waddr, ram_raddr;
   logic [sbv_pkg::RAM_W-1:0] ram_wdata, ram_rdata;
   logic signed [sbv_pkg::ACC_W-1:0] acc_rd [3];
   logic [sbv_pkg::WSUM_W-1:0] wsum_rd, wsum_new;
   logic [sbv_pkg::WSUM_W:0]   wsum_add;

   logic                   div_start, div_done;
   logic [1:0]             div_sel;
   logic [sbv_pkg::DIVD_W-1:0] div_dvd, div_q;
   logic [sbv_pkg::ACC_W-1:0]  div_mag;
   logic signed [W-1:0]    q_sat;

   logic                   accept, vert_ok;

   function automatic logic [3:0] idx3(input logic [1:0] row, input logic [1:0] col);
      return ({2'b00, row} << 1) + {2'b00, row} + {2'b00, col};
   endfunction

   // Unpack the accumulator row
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc_rd[c] = $signed(ram_rdata[c*sbv_pkg::ACC_W +: sbv_pkg::ACC_W]);
      end
   end
   assign wsum_rd  = ram_rdata[sbv_pkg::WSUM_LO +: sbv_pkg::WSUM_W];
   assign wsum_add = {1'b0, wsum_rd} + (sbv_pkg::WSUM_W + 1)'(weight_ff);
   assign wsum_new = wsum_add[sbv_pkg::WSUM_W] ? '1 : wsum_add[sbv_pkg::WSUM_W-1:0];

   assign accept  = req_valid && req_ready;
   assign vert_ok = ({1'b0, req_vertex_index} < vcount_ff) &&
                    (32'(req_vertex_index) < 32'(sbv_pkg::MAX_VERTS));

   // Select transform words and multiplier operands for the current step
   always_comb begin
      par_idx = idx3(i_ff, k_ff);
      loc_idx = idx3(k_ff, j_ff);
      act_idx = idx3(i_ff, k_ff);
      unique case (phase_ff)
         PH_TDOT: loc_idx = 4'(sbv_pkg::XF_TX) + {2'b00, k_ff};
         PH_TSCL: par_idx = 4'(sbv_pkg::XF_SCALE);
         PH_CSCL: begin
            par_idx = 4'(sbv_pkg::XF_SCALE);
            loc_idx = 4'(sbv_pkg::XF_SCALE);
         end
         PH_RSCL: act_idx = 4'(sbv_pkg::XF_SCALE);
         default: ;
      endcase
      if (state_ff == ST_CONS) begin
         par_idx = 4'(sbv_pkg::XF_TX) + {2'b00, i_ff};
         act_idx = 4'(sbv_pkg::XF_TX) + {2'b00, i_ff};
      end
   end

   assign par_rd = parent_ff[par_idx];
   assign loc_rd = local_ff[loc_idx];
   assign act_rd = active_ff[act_idx];

   always_comb begin
      unique case (phase_ff)
         PH_ROT, PH_TDOT, PH_CSCL: begin
            mul_a = sbv_pkg::MUL_W'(par_rd);
            mul_b = sbv_pkg::MUL_W'(loc_rd);
         end
         PH_TSCL: begin
            mul_a = sbv_pkg::MUL_W'(par_rd);
            mul_b = sbv_pkg::MUL_W'(hold_ff);
         end
         PH_RDOT: begin
            mul_a = sbv_pkg::MUL_W'(act_rd);
            mul_b = sbv_pkg::MUL_W'(pin_ff[k_ff]);
         end
         PH_RSCL: begin
            mul_a = sbv_pkg::MUL_W'(act_rd);
            mul_b = sbv_pkg::MUL_W'(hold_ff);
         end
         default: begin
            mul_a = $signed({{(sbv_pkg::MUL_W - sbv_pkg::WGT_W){1'b0}}, weight_ff});
            mul_b = sbv_pkg::MUL_W'(r_ff[k_ff]);
         end
      endcase
   end

   always_comb begin
      unique case (phase_ff)
         PH_TSCL: offset = par_rd;
         PH_RSCL: offset = act_rd;
         default: offset = '0;
      endcase
   end

   assign s_dot = sum_ff + sbv_pkg::SUM_W'(mul_prod);
   assign s_scl = sbv_pkg::SUM_W'(offset) + sbv_pkg::SUM_W'(mul_prod);

   // Divider operand: magnitude of the selected sum, shifted up by the weight fraction
   always_comb begin
      div_mag = acc_rd[div_sel][sbv_pkg::ACC_W-1] ? sbv_pkg::ACC_W'(-acc_rd[div_sel])
                                                 : sbv_pkg::ACC_W'(acc_rd[div_sel]);
      div_dvd = {div_mag, {sbv_pkg::WEIGHT_FRAC{1'b0}}};
   end

   // Saturate the quotient with the sign of its sum
   always_comb begin
      if (acc_rd[comp_ff][sbv_pkg::ACC_W-1]) begin
         q_sat = (div_q > 64'h8000_0000) ? W'(sbv_pkg::S32_MIN)
                                         : W'(sbv_pkg::DIVD_W'(0) - div_q);
      end else begin
         q_sat = (div_q > 64'h7FFF_FFFF) ? W'(sbv_pkg::S32_MAX) : W'(div_q);
      end
   end

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      op_in         = op_ff;
      vidx_in       = vidx_ff;
      pin_in        = pin_ff;
      weight_in     = weight_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      comp_in       = comp_ff;
      sum_in        = sum_ff;
      hold_in       = hold_ff;
      r_in          = r_ff;
      acc_in        = acc_ff;
      fb_in         = fb_ff;
      clr_in        = clr_ff;
      parent_in     = parent_ff;
      local_in      = local_ff;
      active_in     = active_ff;
      vcount_in     = vcount_ff;
      rsp_valid_in  = rsp_valid_ff;
      res_in        = res_ff;
      res_vertex_in = res_vertex_ff;
      res_fb_in     = res_fb_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = VW'(vidx_ff);
      ram_raddr     = VW'(req_vertex_index);
      ram_wdata     = '0;
      div_start     = 1'b0;
      div_sel       = 2'd0;
      req_ready     = (state_ff == ST_IDLE);

      // Drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         vcount_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == VW'(sbv_pkg::MAX_VERTS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               op_in     = sbv_pkg::op_type'(req_operation);
               vidx_in   = req_vertex_index;
               pin_in[0] = req_pos_x;
               pin_in[1] = req_pos_y;
               pin_in[2] = req_pos_z;
               weight_in = req_weight;
               i_in      = 2'd0;
               j_in      = 2'd0;
               k_in      = 2'd0;
               sum_in    = '0;
               fb_in     = 1'b0;
               unique case (req_operation)
                  sbv_pkg::OP_LOAD: begin
                     if (req_word_index < 4'(sbv_pkg::XF_WORDS)) begin
                        if (req_bank) begin
                           local_in[req_word_index] = req_word_value;
                        end else begin
                           parent_in[req_word_index] = req_word_value;
                        end
                     end
                  end
                  sbv_pkg::OP_COMPOSE: begin
                     phase_in = PH_ROT;
                     state_in = ST_ISSUE;
                  end
                  sbv_pkg::OP_ACCUM: begin
                     if (vert_ok) begin
                        ram_re   = 1'b1;
                        phase_in = PH_RDOT;
                        state_in = ST_ISSUE;
                     end
                  end
                  sbv_pkg::OP_EMIT: begin
                     if (vert_ok) begin
                        ram_re   = 1'b1;
                        state_in = ST_EMRD;
                     end
                  end
                  sbv_pkg::OP_RIGID, sbv_pkg::OP_DIR: begin
                     phase_in = PH_RDOT;
                     state_in = ST_ISSUE;
                  end
                  default: ;
               endcase
            end
         end

         ST_ISSUE: begin
            state_in = ST_CONS;
         end

         ST_CONS: begin
            state_in = ST_ISSUE;
            unique case (phase_ff)
               PH_ROT, PH_TDOT, PH_RDOT: begin
                  if (k_ff != 2'd2) begin
                     sum_in = s_dot;
                     k_in   = k_ff + 1'b1;
                  end else begin
                     sum_in = '0;
                     k_in   = 2'd0;
                     if (phase_ff == PH_ROT) begin
                        // Store one rotation entry and advance row-major
                        active_in[idx3(i_ff, j_ff)] = sbv_pkg::sat32(s_dot);
                        if (j_ff == 2'd2) begin
                           j_in = 2'd0;
                           if (i_ff == 2'd2) begin
                              i_in     = 2'd0;
                              phase_in = PH_TDOT;
                           end else begin
                              i_in = i_ff + 1'b1;
                           end
                        end else begin
                           j_in = j_ff + 1'b1;
                        end
                     end else if (phase_ff == PH_TDOT) begin
                        hold_in  = sbv_pkg::sat32(s_dot);
                        phase_in = PH_TSCL;
                     end else if (op_ff == sbv_pkg::OP_DIR) begin
                        r_in[i_ff] = sbv_pkg::sat32(s_dot);
                        if (i_ff == 2'd2) begin
                           state_in = ST_FIN;
                        end else begin
                           i_in = i_ff + 1'b1;
                        end
                     end else begin
                        hold_in  = sbv_pkg::sat32(s_dot);
                        phase_in = PH_RSCL;
                     end
                  end
               end
               PH_TSCL: begin
                  active_in[sbv_pkg::XF_TX + 32'(i_ff)] = sbv_pkg::sat32(s_scl);
                  if (i_ff == 2'd2) begin
                     i_in     = 2'd0;
                     phase_in = PH_CSCL;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     phase_in = PH_TDOT;
                  end
               end
               PH_CSCL: begin
                  active_in[sbv_pkg::XF_SCALE] = sbv_pkg::sat32(s_scl);
                  state_in = ST_IDLE;
               end
               PH_RSCL: begin
                  r_in[i_ff] = sbv_pkg::sat32(s_scl);
                  if (i_ff != 2'd2) begin
                     i_in     = i_ff + 1'b1;
                     phase_in = PH_RDOT;
                  end else if (op_ff == sbv_pkg::OP_RIGID) begin
                     state_in = ST_FIN;
                  end else begin
                     k_in     = 2'd0;
                     phase_in = PH_WGT;
                  end
               end
               default: begin
                  // Weighted contribution into the saturating sums
                  acc_in[k_ff] = sbv_pkg::sat48(sbv_pkg::SUM_W'(acc_rd[k_ff]) +
                                                sbv_pkg::SUM_W'(mul_prod));
                  if (k_ff == 2'd2) begin
                     state_in = ST_WRITE;
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end
            endcase
         end

         ST_EMRD: begin
            if (wsum_rd > sbv_pkg::WSUM_MIN) begin
               comp_in   = 2'd0;
               div_sel   = 2'd0;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               r_in     = pin_ff;
               fb_in    = 1'b1;
               state_in = ST_WRITE;
            end
         end

         ST_DIV: begin
            if (div_done) begin
               r_in[comp_ff] = q_sat;
               if (comp_ff == 2'd2) begin
                  state_in = ST_WRITE;
               end else begin
                  comp_in   = comp_ff + 1'b1;
                  div_sel   = comp_ff + 1'b1;
                  div_start = 1'b1;
               end
            end
         end

         ST_WRITE: begin
            ram_we = 1'b1;
            if (op_ff == sbv_pkg::OP_EMIT) begin
               state_in = ST_FIN;
            end else begin
               ram_wdata = {wsum_new, acc_ff[2], acc_ff[1], acc_ff[0]};
               state_in  = ST_IDLE;
            end
         end

         ST_FIN: begin
            // Hand over to the response register when it is free
            if (!rsp_valid_ff || rsp_ready) begin
               res_in        = r_ff;
               res_vertex_in = (op_ff == sbv_pkg::OP_EMIT) ? vidx_ff : 12'd0;
               res_fb_in     = fb_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         vcount_ff    <= 13'd4096;
         for (int n = 0; n < sbv_pkg::XF_WORDS; n++) begin
            parent_ff[n] <= sbv_pkg::xf_reset(n);
            local_ff[n]  <= sbv_pkg::xf_reset(n);
            active_ff[n] <= sbv_pkg::xf_reset(n);
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         vcount_ff    <= vcount_in;
         parent_ff    <= parent_in;
         local_ff     <= local_in;
         active_ff    <= active_in;
      end
      phase_ff      <= phase_in;
      op_ff         <= op_in;
      vidx_ff       <= vidx_in;
      pin_ff        <= pin_in;
      weight_ff     <= weight_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      comp_ff       <= comp_in;
      sum_ff        <= sum_in;
      hold_ff       <= hold_in;
      r_ff          <= r_in;
      acc_ff        <= acc_in;
      fb_ff         <= fb_in;
      res_ff        <= res_in;
      res_vertex_ff <= res_vertex_in;
      res_fb_ff     <= res_fb_in;
   end

   sbv_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod)
   );

   sbv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (wsum_rd),
      .done     (div_done),
      .quotient (div_q)
   );

   sbv_ram #(
      .WIDTH (sbv_pkg::RAM_W),
      .DEPTH (sbv_pkg::MAX_VERTS)
   ) u_acc_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_res_x         = res_ff[0];
   assign rsp_res_y         = res_ff[1];
   assign rsp_res_z         = res_ff[2];
   assign rsp_res_vertex    = res_vertex_ff;
   assign rsp_used_fallback = res_fb_ff;

   // A division only finishes while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside division wait");

   // Every issued product is consumed in the following cycle
   a_issue_cons: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ISSUE |=> state_ff == ST_CONS)
      else $error("product issue not followed by consume");

   // A new response only comes from the finish step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FIN)
      else $error("response raised outside finish step");

   // No transaction is taken while the accumulator store is swept or written
   a_no_ram_clash: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !accept)
      else $error("transaction accepted during accumulator write");

endmodule

// File: hdl/sbv_ram.sv
// Generic simple dual-port RAM with registered read.
module sbv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/sbv_mul.sv
// Registered signed fixed-point multiplier, product floored by the fraction width.
module sbv_mul (
   input  logic                              clock,
   input  logic signed [sbv_pkg::MUL_W-1:0]  a,
   input  logic signed [sbv_pkg::MUL_W-1:0]  b,
   output logic signed [sbv_pkg::PROD_W-1:0] prod
);

   logic signed [2*sbv_pkg::MUL_W-1:0] full;
   logic signed [sbv_pkg::PROD_W-1:0]  prod_ff;

   assign full = a * b;

   // Drop the fraction bits, which floors toward minus infinity
   always_ff @(posedge clock) begin
      prod_ff <= $signed(full[2*sbv_pkg::MUL_W-1:sbv_pkg::FRAC_BITS]);
   end

   assign prod = prod_ff;

endmodule

// File: hdl/sbv_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module sbv_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [sbv_pkg::DIVD_W-1:0]        dividend,
   input  logic [sbv_pkg::WSUM_W-1:0]        divisor,
   output logic                              done,
   output logic [sbv_pkg::DIVD_W-1:0]        quotient
);

   localparam int CNT_W = $clog2(sbv_pkg::DIVD_W);

   logic [sbv_pkg::DIVD_W-1:0] dvd_ff, dvd_in;
   logic [sbv_pkg::WSUM_W:0]   rem_ff, rem_in;
   logic [sbv_pkg::WSUM_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [sbv_pkg::WSUM_W:0]   rem_sh;

   // Shift in one dividend bit, subtract when the divisor fits
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[sbv_pkg::WSUM_W-1:0], dvd_ff[sbv_pkg::DIVD_W-1]};
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(sbv_pkg::DIVD_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = rem_sh - {1'b0, dsr_ff};
            dvd_in = {dvd_ff[sbv_pkg::DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            dvd_in = {dvd_ff[sbv_pkg::DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule
